// File: hw/rtl/assert_macros.svh
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property checked on every clock edge outside reset
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// condition that must never be seen
`define ASSERT_NEVER(lbl, expr, msg) \
	`ASSERT_CLK(lbl, !(expr), msg)

`endif

// File: hw/rtl/pdd_pkg.sv
`default_nettype none

package pdd_pkg;

	localparam int COORD_BITS = 12;
	localparam int DEPTH_BITS = 16;

	localparam int COL_W      = 12;
	localparam int DEP_W      = 16;
	localparam int CTR_W      = 16;
	localparam int INV_W      = 32;
	localparam int Q_W        = 32;
	localparam int OUT_W      = 48;
	localparam int Z_W        = 16;
	localparam int CFG_IDX_W  = 8;
	localparam int CFG_DATA_W = 64;

	localparam int FRAC   = 28;
	localparam int NSHIFT = 8;
	localparam int DSHIFT = 12;

	localparam int PIX_W   = COORD_BITS + 4;
	localparam int DIFF_W  = ((PIX_W > CTR_W) ? PIX_W : CTR_W) + 1;
	localparam int NPROD_W = DIFF_W + INV_W + 1;
	localparam int DPROD_W = DEPTH_BITS + 1 + Q_W;
	localparam int SUM_W   = 36;

	localparam int NSTAGES  = 17;
	localparam int ST_NORM  = 0;
	localparam int ST_DIST  = 2;
	localparam int ST_SCALE = 15;

	localparam logic [CFG_IDX_W-1:0] REG_CENTER_X        = CFG_IDX_W'(0);
	localparam logic [CFG_IDX_W-1:0] REG_CENTER_Y        = CFG_IDX_W'(1);
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_X     = CFG_IDX_W'(2);
	localparam logic [CFG_IDX_W-1:0] REG_INV_FOCAL_Y     = CFG_IDX_W'(3);
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K1       = CFG_IDX_W'(4);
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K2       = CFG_IDX_W'(5);
	localparam logic [CFG_IDX_W-1:0] REG_RADIAL_K3       = CFG_IDX_W'(6);
	localparam logic [CFG_IDX_W-1:0] REG_TANGENTIAL_PAIR = CFG_IDX_W'(7);

	typedef logic signed [Q_W-1:0]     q_t;
	typedef logic signed [2*Q_W-1:0]   prod_t;
	typedef logic signed [SUM_W-1:0]   sum_t;
	typedef logic signed [DIFF_W-1:0]  diff_t;
	typedef logic signed [NPROD_W-1:0] nprod_t;
	typedef logic signed [DPROD_W-1:0] dprod_t;
	typedef logic signed [OUT_W-1:0]   out_t;
	typedef logic [COORD_BITS-1:0]     coord_t;
	typedef logic [DEPTH_BITS-1:0]     dep_t;
	typedef logic [NSTAGES-1:0]        stage_vec_t;

	localparam logic [CTR_W-1:0] CENTER_X_RST = CTR_W'(32768);
	localparam logic [CTR_W-1:0] CENTER_Y_RST = CTR_W'(24576);
	localparam logic [INV_W-1:0] INV_FOCAL_RST = INV_W'(7158278);

	localparam q_t     Q_ONE  = q_t'(1 << FRAC);
	localparam q_t     Q_MAX  = {1'b0, {(Q_W-1){1'b1}}};
	localparam q_t     Q_MIN  = {1'b1, {(Q_W-1){1'b0}}};
	localparam prod_t  Q_HALF = prod_t'(1 << (FRAC - 1));
	localparam nprod_t N_HALF = nprod_t'(1 << (NSHIFT - 1));
	localparam dprod_t D_HALF = dprod_t'(1 << (DSHIFT - 1));

	typedef struct packed {
		logic [CTR_W-1:0] center_x;
		logic [CTR_W-1:0] center_y;
		logic [INV_W-1:0] inv_focal_x;
		logic [INV_W-1:0] inv_focal_y;
		q_t               k1;
		q_t               k2;
		q_t               k3;
		q_t               p1;
		q_t               p2;
	} cfg_t;

	typedef struct packed {
		stage_vec_t en;
		stage_vec_t vld;
	} pipe_ctl_t;

	function automatic q_t sat32(input sum_t v);
		if (&v[SUM_W-1:Q_W-1] || ~|v[SUM_W-1:Q_W-1]) begin
			return q_t'(v);
		end
		return v[SUM_W-1] ? Q_MIN : Q_MAX;
	endfunction

	// q4.28 product back to q4.28, round half up
	function automatic q_t qmul_fin(input prod_t p);
		prod_t r;
		r = p + Q_HALF;
		r = r >>> FRAC;
		return sat32(sum_t'(r));
	endfunction

	function automatic q_t norm_fin(input nprod_t p);
		nprod_t r;
		r = p + N_HALF;
		r = r >>> NSHIFT;
		if (&r[NPROD_W-1:Q_W-1] || ~|r[NPROD_W-1:Q_W-1]) begin
			return q_t'(r);
		end
		return r[NPROD_W-1] ? Q_MIN : Q_MAX;
	endfunction

	// depth times q4.28 always fits q32.16 after the shift
	function automatic out_t scale_fin(input dprod_t p);
		dprod_t r;
		r = p + D_HALF;
		r = r >>> DSHIFT;
		return out_t'(r);
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/pdd_channels.sv
`default_nettype none

interface pdd_pixel_if import pdd_pkg::*; ();
	logic             valid;
	logic             ready;
	logic [COL_W-1:0] pixel_column;
	logic [COL_W-1:0] pixel_line;
	logic [DEP_W-1:0] depth_value;

	modport source(output valid, pixel_column, pixel_line, depth_value, input ready);
	modport sink(input valid, pixel_column, pixel_line, depth_value, output ready);
endinterface

interface pdd_point_if import pdd_pkg::*; ();
	logic           valid;
	logic           ready;
	out_t           point_x;
	out_t           point_y;
	logic [Z_W-1:0] point_z;

	modport source(output valid, point_x, point_y, point_z, input ready);
	modport sink(input valid, point_x, point_y, point_z, output ready);
endinterface

interface pdd_cfg_if import pdd_pkg::*; ();
	logic                  valid;
	logic                  ready;
	logic [CFG_IDX_W-1:0]  index;
	logic [CFG_DATA_W-1:0] data;

	modport source(output valid, index, data, input ready);
	modport sink(input valid, index, data, output ready);
endinterface

`default_nettype wire

// File: hw/rtl/pdd_ctrl.sv
`default_nettype none

module pdd_ctrl import pdd_pkg::*; (
	input  wire logic clk,
	input  wire logic arst_n,
	input  wire logic in_valid,
	input  wire logic out_ready,
	output pipe_ctl_t ctl
);

	stage_vec_t vld_q;
	stage_vec_t en;

	// a stage loads when the output is ready or when it or any stage after it has a hole
	always_comb begin
		for (int i = 0; i < NSTAGES; i++) begin
			en[i] = out_ready | ~&(vld_q | stage_vec_t'((64'd1 << i) - 64'd1));
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else begin
			vld_q <= (en & {vld_q[NSTAGES-2:0], in_valid}) | (~en & vld_q);
		end
	end

	assign ctl.en  = en;
	assign ctl.vld = vld_q;

endmodule

`default_nettype wire

// File: hw/rtl/pdd_cfg.sv
`default_nettype none

module pdd_cfg import pdd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pdd_cfg_if.sink    cfg,
	output cfg_t       regs
);

	logic [CTR_W-1:0]      center_x_q;
	logic [CTR_W-1:0]      center_y_q;
	logic [INV_W-1:0]      inv_focal_x_q;
	logic [INV_W-1:0]      inv_focal_y_q;
	q_t                    k1_q;
	q_t                    k2_q;
	q_t                    k3_q;
	logic [CFG_DATA_W-1:0] tang_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q    <= CENTER_X_RST;
			center_y_q    <= CENTER_Y_RST;
			inv_focal_x_q <= INV_FOCAL_RST;
			inv_focal_y_q <= INV_FOCAL_RST;
			k1_q          <= '0;
			k2_q          <= '0;
			k3_q          <= '0;
			tang_q        <= '0;
		end else if (cfg.valid) begin
			case (cfg.index)
				REG_CENTER_X:        center_x_q    <= cfg.data[CTR_W-1:0];
				REG_CENTER_Y:        center_y_q    <= cfg.data[CTR_W-1:0];
				REG_INV_FOCAL_X:     inv_focal_x_q <= cfg.data[INV_W-1:0];
				REG_INV_FOCAL_Y:     inv_focal_y_q <= cfg.data[INV_W-1:0];
				REG_RADIAL_K1:       k1_q          <= q_t'(cfg.data[Q_W-1:0]);
				REG_RADIAL_K2:       k2_q          <= q_t'(cfg.data[Q_W-1:0]);
				REG_RADIAL_K3:       k3_q          <= q_t'(cfg.data[Q_W-1:0]);
				REG_TANGENTIAL_PAIR: tang_q        <= cfg.data;
				default: begin
				end
			endcase
		end
	end

	assign regs.center_x    = center_x_q;
	assign regs.center_y    = center_y_q;
	assign regs.inv_focal_x = inv_focal_x_q;
	assign regs.inv_focal_y = inv_focal_y_q;
	assign regs.k1          = k1_q;
	assign regs.k2          = k2_q;
	assign regs.k3          = k3_q;
	assign regs.p1          = q_t'(tang_q[Q_W-1:0]);
	assign regs.p2          = q_t'(tang_q[2*Q_W-1:Q_W]);

endmodule

`default_nettype wire

// File: hw/rtl/pdd_normalize.sv
`default_nettype none

module pdd_normalize import pdd_pkg::*; (
	input  wire logic             clk,
	input  wire pipe_ctl_t        ctl,
	input  wire cfg_t             regs,
	input  wire logic [COL_W-1:0] pixel_column,
	input  wire logic [COL_W-1:0] pixel_line,
	input  wire logic [DEP_W-1:0] depth_value,
	output q_t                    x,
	output q_t                    y,
	output dep_t                  dep
);

	coord_t col;
	coord_t row;
	diff_t  dx;
	diff_t  dy;

	nprod_t px_s1;
	nprod_t py_s1;
	dep_t   dep_s1;
	q_t     x_s2;
	q_t     y_s2;
	dep_t   dep_s2;

	assign col = coord_t'(pixel_column);
	assign row = coord_t'(pixel_line);
	assign dx  = diff_t'(DIFF_W'({col, 4'b0000}) - DIFF_W'(regs.center_x));
	assign dy  = diff_t'(DIFF_W'({row, 4'b0000}) - DIFF_W'(regs.center_y));

	always_ff @(posedge clk) begin
		if (ctl.en[ST_NORM]) begin
			px_s1  <= dx * signed'({1'b0, regs.inv_focal_x});
			py_s1  <= dy * signed'({1'b0, regs.inv_focal_y});
			dep_s1 <= dep_t'(depth_value);
		end
		if (ctl.en[ST_NORM+1]) begin
			x_s2   <= norm_fin(px_s1);
			y_s2   <= norm_fin(py_s1);
			dep_s2 <= dep_s1;
		end
	end

	assign x   = x_s2;
	assign y   = y_s2;
	assign dep = dep_s2;

endmodule

`default_nettype wire

// File: hw/rtl/pdd_distort.sv
`default_nettype none

module pdd_distort import pdd_pkg::*; (
	input  wire logic      clk,
	input  wire pipe_ctl_t ctl,
	input  wire cfg_t      regs,
	input  wire q_t        x,
	input  wire q_t        y,
	input  wire dep_t      dep,
	output q_t             ux,
	output q_t             uy,
	output dep_t           dep_out
);

	prod_t pxx_s3, pyy_s3, pxy_s3;
	q_t    x_s3, y_s3;
	dep_t  dep_s3;

	q_t    xx_s4, yy_s4, xy_s4, x_s4, y_s4;
	dep_t  dep_s4;

	q_t    r2_s5, xx_s5, yy_s5, xy_s5, x_s5, y_s5;
	dep_t  dep_s5;

	prod_t pr4_s6, pk1_s6, pp1xy_s6, pp2xy_s6;
	q_t    tx_s6, ty_s6, r2_s6, x_s6, y_s6;
	dep_t  dep_s6;

	q_t    r4_s7, k1r2_s7, p1xy_s7, p2xy_s7, r2_s7, x_s7, y_s7;
	prod_t pp2tx_s7, pp1ty_s7;
	dep_t  dep_s7;

	prod_t pr6_s8, pk2_s8;
	q_t    p2tx_s8, p1ty_s8, k1r2_s8, p1xy_s8, p2xy_s8, x_s8, y_s8;
	dep_t  dep_s8;

	q_t    r6_s9, k2r4_s9, k1r2_s9, p1xy_s9, p2xy_s9, p2tx_s9, p1ty_s9, x_s9, y_s9;
	dep_t  dep_s9;

	prod_t pk3_s10;
	sum_t  part_s10;
	q_t    p1xy_s10, p2xy_s10, p2tx_s10, p1ty_s10, x_s10, y_s10;
	dep_t  dep_s10;

	q_t    k3r6_s11;
	sum_t  part_s11;
	q_t    p1xy_s11, p2xy_s11, p2tx_s11, p1ty_s11, x_s11, y_s11;
	dep_t  dep_s11;

	q_t    f_s12, p1xy_s12, p2xy_s12, p2tx_s12, p1ty_s12, x_s12, y_s12;
	dep_t  dep_s12;

	prod_t pxf_s13, pyf_s13;
	q_t    p1xy_s13, p2xy_s13, p2tx_s13, p1ty_s13;
	dep_t  dep_s13;

	q_t    xf_s14, yf_s14, p1xy_s14, p2xy_s14, p2tx_s14, p1ty_s14;
	dep_t  dep_s14;

	q_t    ux_s15, uy_s15;
	dep_t  dep_s15;

	always_ff @(posedge clk) begin
		// squares and cross term
		if (ctl.en[ST_DIST]) begin
			pxx_s3 <= x * x;
			pyy_s3 <= y * y;
			pxy_s3 <= x * y;
			x_s3   <= x;
			y_s3   <= y;
			dep_s3 <= dep;
		end
		if (ctl.en[ST_DIST+1]) begin
			xx_s4  <= qmul_fin(pxx_s3);
			yy_s4  <= qmul_fin(pyy_s3);
			xy_s4  <= qmul_fin(pxy_s3);
			x_s4   <= x_s3;
			y_s4   <= y_s3;
			dep_s4 <= dep_s3;
		end
		if (ctl.en[ST_DIST+2]) begin
			r2_s5  <= sat32(sum_t'(xx_s4) + sum_t'(yy_s4));
			xx_s5  <= xx_s4;
			yy_s5  <= yy_s4;
			xy_s5  <= xy_s4;
			x_s5   <= x_s4;
			y_s5   <= y_s4;
			dep_s5 <= dep_s4;
		end
		if (ctl.en[ST_DIST+3]) begin
			pr4_s6   <= r2_s5 * r2_s5;
			pk1_s6   <= regs.k1 * r2_s5;
			pp1xy_s6 <= regs.p1 * xy_s5;
			pp2xy_s6 <= regs.p2 * xy_s5;
			tx_s6    <= sat32(sum_t'(r2_s5) + (sum_t'(xx_s5) <<< 1));
			ty_s6    <= sat32(sum_t'(r2_s5) + (sum_t'(yy_s5) <<< 1));
			r2_s6    <= r2_s5;
			x_s6     <= x_s5;
			y_s6     <= y_s5;
			dep_s6   <= dep_s5;
		end
		if (ctl.en[ST_DIST+4]) begin
			r4_s7    <= qmul_fin(pr4_s6);
			k1r2_s7  <= qmul_fin(pk1_s6);
			p1xy_s7  <= qmul_fin(pp1xy_s6);
			p2xy_s7  <= qmul_fin(pp2xy_s6);
			pp2tx_s7 <= regs.p2 * tx_s6;
			pp1ty_s7 <= regs.p1 * ty_s6;
			r2_s7    <= r2_s6;
			x_s7     <= x_s6;
			y_s7     <= y_s6;
			dep_s7   <= dep_s6;
		end
		if (ctl.en[ST_DIST+5]) begin
			pr6_s8  <= r4_s7 * r2_s7;
			pk2_s8  <= regs.k2 * r4_s7;
			p2tx_s8 <= qmul_fin(pp2tx_s7);
			p1ty_s8 <= qmul_fin(pp1ty_s7);
			k1r2_s8 <= k1r2_s7;
			p1xy_s8 <= p1xy_s7;
			p2xy_s8 <= p2xy_s7;
			x_s8    <= x_s7;
			y_s8    <= y_s7;
			dep_s8  <= dep_s7;
		end
		if (ctl.en[ST_DIST+6]) begin
			r6_s9   <= qmul_fin(pr6_s8);
			k2r4_s9 <= qmul_fin(pk2_s8);
			k1r2_s9 <= k1r2_s8;
			p1xy_s9 <= p1xy_s8;
			p2xy_s9 <= p2xy_s8;
			p2tx_s9 <= p2tx_s8;
			p1ty_s9 <= p1ty_s8;
			x_s9    <= x_s8;
			y_s9    <= y_s8;
			dep_s9  <= dep_s8;
		end
		// radial factor, exact partial sum
		if (ctl.en[ST_DIST+7]) begin
			pk3_s10  <= regs.k3 * r6_s9;
			part_s10 <= sum_t'(Q_ONE) + sum_t'(k1r2_s9) + sum_t'(k2r4_s9);
			p1xy_s10 <= p1xy_s9;
			p2xy_s10 <= p2xy_s9;
			p2tx_s10 <= p2tx_s9;
			p1ty_s10 <= p1ty_s9;
			x_s10    <= x_s9;
			y_s10    <= y_s9;
			dep_s10  <= dep_s9;
		end
		if (ctl.en[ST_DIST+8]) begin
			k3r6_s11 <= qmul_fin(pk3_s10);
			part_s11 <= part_s10;
			p1xy_s11 <= p1xy_s10;
			p2xy_s11 <= p2xy_s10;
			p2tx_s11 <= p2tx_s10;
			p1ty_s11 <= p1ty_s10;
			x_s11    <= x_s10;
			y_s11    <= y_s10;
			dep_s11  <= dep_s10;
		end
		if (ctl.en[ST_DIST+9]) begin
			f_s12    <= sat32(part_s11 + sum_t'(k3r6_s11));
			p1xy_s12 <= p1xy_s11;
			p2xy_s12 <= p2xy_s11;
			p2tx_s12 <= p2tx_s11;
			p1ty_s12 <= p1ty_s11;
			x_s12    <= x_s11;
			y_s12    <= y_s11;
			dep_s12  <= dep_s11;
		end
		if (ctl.en[ST_DIST+10]) begin
			pxf_s13  <= x_s12 * f_s12;
			pyf_s13  <= y_s12 * f_s12;
			p1xy_s13 <= p1xy_s12;
			p2xy_s13 <= p2xy_s12;
			p2tx_s13 <= p2tx_s12;
			p1ty_s13 <= p1ty_s12;
			dep_s13  <= dep_s12;
		end
		if (ctl.en[ST_DIST+11]) begin
			xf_s14   <= qmul_fin(pxf_s13);
			yf_s14   <= qmul_fin(pyf_s13);
			p1xy_s14 <= p1xy_s13;
			p2xy_s14 <= p2xy_s13;
			p2tx_s14 <= p2tx_s13;
			p1ty_s14 <= p1ty_s13;
			dep_s14  <= dep_s13;
		end
		// radial plus tangential terms
		if (ctl.en[ST_DIST+12]) begin
			ux_s15  <= sat32(sum_t'(xf_s14) + (sum_t'(p1xy_s14) <<< 1) + sum_t'(p2tx_s14));
			uy_s15  <= sat32(sum_t'(yf_s14) + (sum_t'(p2xy_s14) <<< 1) + sum_t'(p1ty_s14));
			dep_s15 <= dep_s14;
		end
	end

	assign ux      = ux_s15;
	assign uy      = uy_s15;
	assign dep_out = dep_s15;

endmodule

`default_nettype wire

// File: hw/rtl/pdd_scale.sv
`default_nettype none

module pdd_scale import pdd_pkg::*; (
	input  wire logic      clk,
	input  wire pipe_ctl_t ctl,
	input  wire q_t        ux,
	input  wire q_t        uy,
	input  wire dep_t      dep,
	output out_t           point_x,
	output out_t           point_y,
	output logic [Z_W-1:0] point_z
);

	dprod_t         pdx_s16;
	dprod_t         pdy_s16;
	dep_t           dep_s16;
	out_t           point_x_s17;
	out_t           point_y_s17;
	logic [Z_W-1:0] point_z_s17;

	always_ff @(posedge clk) begin
		if (ctl.en[ST_SCALE]) begin
			pdx_s16 <= signed'({1'b0, dep}) * ux;
			pdy_s16 <= signed'({1'b0, dep}) * uy;
			dep_s16 <= dep;
		end
		if (ctl.en[ST_SCALE+1]) begin
			point_x_s17 <= scale_fin(pdx_s16);
			point_y_s17 <= scale_fin(pdy_s16);
			point_z_s17 <= Z_W'(dep_s16);
		end
	end

	assign point_x = point_x_s17;
	assign point_y = point_y_s17;
	assign point_z = point_z_s17;

endmodule

`default_nettype wire

// File: hw/rtl/pixel_depth_deprojection.sv
// channel  dir  payload                                    handshake
// pixel    in   pixel_column, pixel_line, depth_value      valid/ready
// point    out  point_x, point_y (q32.16), point_z         valid/ready
// cfg      in   index (8 bits), data (64 bits)             valid/ready, ready tied high
//
// one item per cycle sustained while point.ready is high
// each item passes through the 17-stage chain of multiply and round/saturate steps
// arst_n clears the valid bits and loads the register reset values
// on a stall each stage still loads while it or a later stage has a hole
`default_nettype none
`include "assert_macros.svh"

module pixel_depth_deprojection import pdd_pkg::*; (
	input  wire logic  clk,
	input  wire logic  arst_n,
	pdd_pixel_if.sink  pixel,
	pdd_point_if.source point,
	pdd_cfg_if.sink    cfg
);

	pipe_ctl_t ctl;
	cfg_t      regs;
	q_t        x, y, ux, uy;
	dep_t      dep_n, dep_d;
	logic      in_acc, out_acc;

	pdd_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (pixel.valid),
		.out_ready (point.ready),
		.ctl       (ctl)
	);

	pdd_cfg u_cfg (
		.clk    (clk),
		.arst_n (arst_n),
		.cfg    (cfg),
		.regs   (regs)
	);

	pdd_normalize u_norm (
		.clk          (clk),
		.ctl          (ctl),
		.regs         (regs),
		.pixel_column (pixel.pixel_column),
		.pixel_line   (pixel.pixel_line),
		.depth_value  (pixel.depth_value),
		.x            (x),
		.y            (y),
		.dep          (dep_n)
	);

	pdd_distort u_dist (
		.clk     (clk),
		.ctl     (ctl),
		.regs    (regs),
		.x       (x),
		.y       (y),
		.dep     (dep_n),
		.ux      (ux),
		.uy      (uy),
		.dep_out (dep_d)
	);

	pdd_scale u_scale (
		.clk     (clk),
		.ctl     (ctl),
		.ux      (ux),
		.uy      (uy),
		.dep     (dep_d),
		.point_x (point.point_x),
		.point_y (point.point_y),
		.point_z (point.point_z)
	);

	assign pixel.ready = ctl.en[0];
	assign point.valid = ctl.vld[NSTAGES-1];

	assign in_acc  = pixel.valid & pixel.ready;
	assign out_acc = point.valid & point.ready;

	`ASSERT_CLK(a_occupancy, arst_n |=> $countones(ctl.vld) == $past($countones(ctl.vld)) + int'($past(in_acc)) - int'($past(out_acc)), "pipeline item count mismatch")
	`ASSERT_CLK(a_drain_opens_intake, point.ready |-> pixel.ready, "intake closed while output drains")
	`ASSERT_NEVER(a_full_stall, (&ctl.vld) && !point.ready && pixel.ready, "intake open with full stalled pipeline")

endmodule

`default_nettype wire

// File: verif/tb.sv
module tb;
	timeunit 1ns;
	timeprecision 1ps;
	import pdd_pkg::*;

	localparam longint Q_LIM_HI = 64'sd2147483647;
	localparam longint Q_LIM_LO = -64'sd2147483648;
	localparam longint OUT_LIM_HI = (64'sd1 <<< (OUT_W - 1)) - 1;
	localparam longint OUT_LIM_LO = -(64'sd1 <<< (OUT_W - 1));
	localparam int FIRST_UNUSED_REG = 8;
	localparam int RAND_PHASES = 8;
	localparam int PHASE_ITEMS = 80;
	localparam int LONG_HOLD = 120;

	typedef enum {CFG_TYPICAL, CFG_ANY, CFG_EDGE} cfg_style_t;

	typedef struct packed {
		out_t           x;
		out_t           y;
		logic [Z_W-1:0] z;
	} point_t;

	typedef struct {
		int               setting;
		logic [COL_W-1:0] col;
		logic [COL_W-1:0] row;
		logic [DEP_W-1:0] depth;
		bit               typed;
		point_t           want;
	} stim_row_t;

	logic clk;
	logic arst_n;

	pdd_pixel_if pixel_ch();
	pdd_point_if point_ch();
	pdd_cfg_if   cfg_ch();

	pixel_depth_deprojection uut (
		.clk    (clk),
		.arst_n (arst_n),
		.pixel  (pixel_ch),
		.point  (point_ch),
		.cfg    (cfg_ch)
	);

	cfg_t       cam_cfg;
	point_t     pending_points[$];
	stim_row_t  dir_table[$];
	cfg_t       dir_settings[4];
	int         mismatches;
	int         points_seen;
	int         items_sent;
	int         writes_done;
	int         settings_used;
	bit         hold_request;

	function automatic longint round_sh(longint v, int s);
		return (v + (longint'(1) <<< (s - 1))) >>> s;
	endfunction

	function automatic longint clamp(longint v, longint lo, longint hi);
		return (v < lo) ? lo : ((v > hi) ? hi : v);
	endfunction

	function automatic longint sat_q(longint v);
		return clamp(v, Q_LIM_LO, Q_LIM_HI);
	endfunction

	function automatic longint qprod(longint a, longint b);
		return sat_q(round_sh(a * b, FRAC));
	endfunction

	function automatic longint norm_coord(logic [COL_W-1:0] pix, logic [CTR_W-1:0] ctr,
			logic [INV_W-1:0] inv);
		longint d;
		d = (longint'(pix) <<< 4) - longint'(ctr);
		return sat_q(round_sh(d * longint'(inv), NSHIFT));
	endfunction

	function automatic out_t scale_depth(logic [DEP_W-1:0] dep, longint q);
		longint v;
		v = clamp(round_sh(longint'(dep) * q, DSHIFT), OUT_LIM_LO, OUT_LIM_HI);
		return out_t'(v);
	endfunction

	function automatic point_t predict_point(cfg_t c, logic [COL_W-1:0] col,
			logic [COL_W-1:0] row, logic [DEP_W-1:0] dep);
		longint x, y, xx, yy, xy, r2, r4, r6, f, ux, uy;
		longint k1, k2, k3, p1, p2;
		point_t p;
		k1 = c.k1;
		k2 = c.k2;
		k3 = c.k3;
		p1 = c.p1;
		p2 = c.p2;
		x = norm_coord(col, c.center_x, c.inv_focal_x);
		y = norm_coord(row, c.center_y, c.inv_focal_y);
		xx = qprod(x, x);
		yy = qprod(y, y);
		xy = qprod(x, y);
		r2 = sat_q(xx + yy);
		r4 = qprod(r2, r2);
		r6 = qprod(r4, r2);
		f = sat_q(longint'(Q_ONE) + qprod(k1, r2) + qprod(k2, r4) + qprod(k3, r6));
		ux = sat_q(qprod(x, f) + 2 * qprod(p1, xy) + qprod(p2, sat_q(r2 + 2 * xx)));
		uy = sat_q(qprod(y, f) + 2 * qprod(p2, xy) + qprod(p1, sat_q(r2 + 2 * yy)));
		p.x = scale_depth(dep, ux);
		p.y = scale_depth(dep, uy);
		p.z = Z_W'(dep);
		return p;
	endfunction

	function automatic logic [31:0] pick_edge_word();
		case ($urandom_range(0, 4))
			0: return 32'h0000_0000;
			1: return 32'h7FFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic q_t small_coef(int frac_bits);
		return q_t'(int'($urandom_range(0, 1 << frac_bits)) - (1 << (frac_bits - 1)));
	endfunction

	function automatic cfg_t random_setting(cfg_style_t style);
		cfg_t c;
		case (style)
			CFG_TYPICAL: begin
				c.center_x    = CTR_W'($urandom_range(16 * 200, 16 * 3900));
				c.center_y    = CTR_W'($urandom_range(16 * 200, 16 * 3900));
				c.inv_focal_x = INV_W'((64'd1 << 32) / $urandom_range(150, 4000));
				c.inv_focal_y = INV_W'((64'd1 << 32) / $urandom_range(150, 4000));
				c.k1          = small_coef(28);
				c.k2          = small_coef(26);
				c.k3          = small_coef(22);
				c.p1          = small_coef(22);
				c.p2          = small_coef(22);
			end
			CFG_ANY: begin
				c.center_x    = CTR_W'($urandom);
				c.center_y    = CTR_W'($urandom);
				c.inv_focal_x = $urandom;
				c.inv_focal_y = $urandom;
				c.k1          = $urandom;
				c.k2          = $urandom;
				c.k3          = $urandom;
				c.p1          = $urandom;
				c.p2          = $urandom;
			end
			default: begin
				c.center_x    = CTR_W'(pick_edge_word());
				c.center_y    = CTR_W'(pick_edge_word());
				c.inv_focal_x = pick_edge_word();
				c.inv_focal_y = pick_edge_word();
				c.k1          = pick_edge_word();
				c.k2          = pick_edge_word();
				c.k3          = pick_edge_word();
				c.p1          = pick_edge_word();
				c.p2          = pick_edge_word();
			end
		endcase
		return c;
	endfunction

	function automatic stim_row_t trow(int s, int c, int r, int d, bit t);
		stim_row_t e;
		e.setting = s;
		e.col     = COL_W'(c);
		e.row     = COL_W'(r);
		e.depth   = DEP_W'(d);
		e.typed   = t;
		e.want.x  = '0;
		e.want.y  = '0;
		e.want.z  = Z_W'(d);
		return e;
	endfunction

	function automatic int gap_len();
		int pick;
		pick = $urandom_range(0, 99);
		if (pick < 65) begin
			return 0;
		end else if (pick < 94) begin
			return $urandom_range(1, 3);
		end
		return $urandom_range(15, 40);
	endfunction

	task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
		cfg_ch.valid <= 1'b1;
		cfg_ch.index <= idx;
		cfg_ch.data  <= data;
		do @(posedge clk); while (!cfg_ch.ready);
		case (idx)
			REG_CENTER_X:        cam_cfg.center_x = data[CTR_W-1:0];
			REG_CENTER_Y:        cam_cfg.center_y = data[CTR_W-1:0];
			REG_INV_FOCAL_X:     cam_cfg.inv_focal_x = data[INV_W-1:0];
			REG_INV_FOCAL_Y:     cam_cfg.inv_focal_y = data[INV_W-1:0];
			REG_RADIAL_K1:       cam_cfg.k1 = data[Q_W-1:0];
			REG_RADIAL_K2:       cam_cfg.k2 = data[Q_W-1:0];
			REG_RADIAL_K3:       cam_cfg.k3 = data[Q_W-1:0];
			REG_TANGENTIAL_PAIR: begin
				cam_cfg.p1 = data[Q_W-1:0];
				cam_cfg.p2 = data[2*Q_W-1:Q_W];
			end
			default: ;
		endcase
		writes_done++;
		@(negedge clk);
	endtask

	// upper data bits of the narrow registers carry junk that must be dropped
	task automatic program_regs(cfg_t s);
		logic [CFG_DATA_W-1:0] junk;
		junk = {$urandom, $urandom};
		write_reg(REG_CENTER_X, {junk[CFG_DATA_W-1:CTR_W], s.center_x});
		write_reg(REG_RADIAL_K3, {junk[CFG_DATA_W-1:Q_W], s.k3});
		write_reg(REG_CENTER_Y, {junk[CFG_DATA_W-1:CTR_W], s.center_y});
		write_reg(CFG_IDX_W'($urandom_range(FIRST_UNUSED_REG, (1 << CFG_IDX_W) - 1)),
			{$urandom, $urandom});
		write_reg(REG_INV_FOCAL_X, {junk[CFG_DATA_W-1:INV_W], s.inv_focal_x});
		write_reg(REG_INV_FOCAL_Y, {~junk[CFG_DATA_W-1:INV_W], s.inv_focal_y});
		write_reg(REG_RADIAL_K1, {~junk[CFG_DATA_W-1:Q_W], s.k1});
		write_reg(REG_RADIAL_K2, {junk[CFG_DATA_W-1:Q_W], s.k2});
		write_reg(REG_TANGENTIAL_PAIR, {s.p2, s.p1});
		cfg_ch.valid <= 1'b0;
		settings_used++;
	endtask

	task automatic send_pixel(logic [COL_W-1:0] c, logic [COL_W-1:0] r,
			logic [DEP_W-1:0] d, bit typed, point_t want);
		pixel_ch.valid        <= 1'b1;
		pixel_ch.pixel_column <= c;
		pixel_ch.pixel_line   <= r;
		pixel_ch.depth_value  <= d;
		do @(posedge clk); while (!pixel_ch.ready);
		pending_points.push_back(typed ? want : predict_point(cam_cfg, c, r, d));
		items_sent++;
		@(negedge clk);
	endtask

	task automatic pause_pixels(int n);
		pixel_ch.valid <= 1'b0;
		repeat (n) @(negedge clk);
	endtask

	task automatic drain_points();
		pixel_ch.valid <= 1'b0;
		while (pending_points.size() != 0) @(negedge clk);
	endtask

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	initial begin
		#2000000;
		$display("pixel_depth_deprojection test failed");
		$finish;
	end

	// output side: random back-pressure, steady stretches and one long hold
	initial begin
		int stall_left;
		int hold_left;
		int mode_left;
		bit steady;
		stall_left = 0;
		hold_left = 0;
		mode_left = 0;
		steady = 1'b0;
		point_ch.ready <= 1'b0;
		forever begin
			@(negedge clk);
			if (hold_request) begin
				hold_request = 1'b0;
				hold_left = LONG_HOLD;
			end
			if (hold_left > 0) begin
				hold_left--;
				point_ch.ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				point_ch.ready <= 1'b0;
			end else begin
				if (mode_left == 0) begin
					steady = ($urandom_range(0, 3) == 0);
					mode_left = $urandom_range(50, 200);
				end
				mode_left--;
				if (!steady && $urandom_range(0, 9) < 3) begin
					stall_left = (($urandom_range(0, 19) == 0) ?
						$urandom_range(15, 40) : $urandom_range(1, 3)) - 1;
					point_ch.ready <= 1'b0;
				end else begin
					point_ch.ready <= 1'b1;
				end
			end
		end
	end

	always @(posedge clk) begin
		point_t want;
		if (arst_n && point_ch.valid && point_ch.ready) begin
			points_seen++;
			if (pending_points.size() == 0) begin
				if (mismatches < 10) begin
					$display("unexpected point x=%0d y=%0d z=%0d", point_ch.point_x,
						point_ch.point_y, point_ch.point_z);
				end
				mismatches++;
			end else begin
				want = pending_points.pop_front();
				if (point_ch.point_x !== want.x || point_ch.point_y !== want.y ||
						point_ch.point_z !== want.z) begin
					if (mismatches < 10) begin
						$display("point %0d: exp x=%0d y=%0d z=%0d, got x=%0d y=%0d z=%0d",
							points_seen, want.x, want.y, want.z, point_ch.point_x,
							point_ch.point_y, point_ch.point_z);
					end
					mismatches++;
				end
			end
		end
	end

	initial begin
		int cur_set;
		int n_gap;
		bit quiet;
		cfg_style_t style;
		point_t none;
		logic [DEP_W-1:0] dep;

		arst_n                <= 1'b0;
		pixel_ch.valid        <= 1'b0;
		pixel_ch.pixel_column <= '0;
		pixel_ch.pixel_line   <= '0;
		pixel_ch.depth_value  <= '0;
		cfg_ch.valid          <= 1'b0;
		cfg_ch.index          <= '0;
		cfg_ch.data           <= '0;
		mismatches = 0;
		points_seen = 0;
		items_sent = 0;
		writes_done = 0;
		settings_used = 1;
		hold_request = 1'b0;
		none = '0;

		cam_cfg.center_x    = CENTER_X_RST;
		cam_cfg.center_y    = CENTER_Y_RST;
		cam_cfg.inv_focal_x = INV_FOCAL_RST;
		cam_cfg.inv_focal_y = INV_FOCAL_RST;
		cam_cfg.k1          = '0;
		cam_cfg.k2          = '0;
		cam_cfg.k3          = '0;
		cam_cfg.p1          = '0;
		cam_cfg.p2          = '0;

		dir_settings[0] = cam_cfg;
		// everything at its limit so the whole chain saturates
		dir_settings[1].center_x    = '0;
		dir_settings[1].center_y    = '1;
		dir_settings[1].inv_focal_x = '1;
		dir_settings[1].inv_focal_y = '1;
		dir_settings[1].k1          = Q_MAX;
		dir_settings[1].k2          = Q_MIN;
		dir_settings[1].k3          = Q_MAX;
		dir_settings[1].p1          = Q_MIN;
		dir_settings[1].p2          = Q_MAX;
		// zero focal reciprocals pin every point to the optical axis
		dir_settings[2].center_x    = 16'h1234;
		dir_settings[2].center_y    = 16'hABCD;
		dir_settings[2].inv_focal_x = '0;
		dir_settings[2].inv_focal_y = '0;
		dir_settings[2].k1          = Q_MIN;
		dir_settings[2].k2          = Q_MAX;
		dir_settings[2].k3          = Q_MAX;
		dir_settings[2].p1          = q_t'(32'h1000_0000);
		dir_settings[2].p2          = Q_MIN;
		// plain lens, principal point at (1000, 700)
		dir_settings[3].center_x    = CTR_W'(16000);
		dir_settings[3].center_y    = CTR_W'(11200);
		dir_settings[3].inv_focal_x = INV_W'(4294967);
		dir_settings[3].inv_focal_y = INV_W'(4294967);
		dir_settings[3].k1          = q_t'(-(1 << 26));
		dir_settings[3].k2          = q_t'(1 << 24);
		dir_settings[3].k3          = q_t'(-(1 << 20));
		dir_settings[3].p1          = q_t'(1 << 20);
		dir_settings[3].p2          = q_t'(-(1 << 19));

		dir_table.push_back(trow(0, 2048, 1536, 1000, 1'b1));
		dir_table.push_back(trow(0, 2048, 1536, 65535, 1'b1));
		dir_table.push_back(trow(0, 0, 0, 0, 1'b1));
		dir_table.push_back(trow(0, 4095, 4095, 0, 1'b1));
		dir_table.push_back(trow(0, 0, 0, 65535, 1'b0));
		dir_table.push_back(trow(0, 4095, 4095, 65535, 1'b0));
		dir_table.push_back(trow(0, 4095, 0, 1, 1'b0));
		dir_table.push_back(trow(0, 0, 4095, 777, 1'b0));
		dir_table.push_back(trow(1, 0, 0, 65535, 1'b0));
		dir_table.push_back(trow(1, 4095, 4095, 65535, 1'b0));
		dir_table.push_back(trow(1, 4095, 0, 1, 1'b0));
		dir_table.push_back(trow(1, 2048, 2048, 0, 1'b1));
		dir_table.push_back(trow(1, 0, 4095, 32768, 1'b0));
		dir_table.push_back(trow(2, 0, 0, 65535, 1'b1));
		dir_table.push_back(trow(2, 4095, 4095, 12345, 1'b1));
		dir_table.push_back(trow(2, 1, 2, 3, 1'b1));
		dir_table.push_back(trow(3, 1000, 700, 5000, 1'b1));
		dir_table.push_back(trow(3, 0, 0, 65535, 1'b0));
		dir_table.push_back(trow(3, 4095, 4095, 65535, 1'b0));
		dir_table.push_back(trow(3, 1010, 690, 1000, 1'b0));
		dir_table.push_back(trow(3, 3000, 100, 40000, 1'b0));

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		cur_set = 0;
		foreach (dir_table[i]) begin
			if (dir_table[i].setting != cur_set) begin
				drain_points();
				cur_set = dir_table[i].setting;
				program_regs(dir_settings[cur_set]);
			end
			send_pixel(dir_table[i].col, dir_table[i].row, dir_table[i].depth,
				dir_table[i].typed, dir_table[i].want);
		end
		drain_points();

		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			if (ph == 0) begin
				style = CFG_TYPICAL;
			end else if (ph == RAND_PHASES - 1) begin
				style = CFG_EDGE;
			end else begin
				case ($urandom_range(0, 3))
					0: style = CFG_ANY;
					1: style = CFG_EDGE;
					default: style = CFG_TYPICAL;
				endcase
			end
			program_regs(random_setting(style));
			quiet = (ph == 2) || ($urandom_range(0, 3) == 0);
			// output blocked while items keep coming: pipeline fills, input stalls
			if (ph == 2) begin
				hold_request = 1'b1;
			end
			for (int i = 0; i < PHASE_ITEMS; i++) begin
				case ($urandom_range(0, 9))
					0: dep = '1;
					1: dep = '0;
					2, 3, 4: dep = DEP_W'($urandom_range(200, 8000));
					default: dep = DEP_W'($urandom);
				endcase
				send_pixel(COL_W'($urandom), COL_W'($urandom), dep, 1'b0, none);
				if (i == PHASE_ITEMS - 1) begin
				end else if (ph == 5 && i == PHASE_ITEMS / 2) begin
					drain_points();
				end else begin
					n_gap = quiet ? 0 : gap_len();
					if (n_gap > 0) begin
						pause_pixels(n_gap);
					end
				end
			end
			drain_points();
		end

		repeat (2 * NSTAGES) @(negedge clk);
		$display("%0d pixel items, %0d points checked, %0d register settings (%0d writes)",
			items_sent, points_seen, settings_used, writes_done);
		$display("covered saturation limits, zero focal scale, junk writes, long output hold");
		if (mismatches == 0) begin
			$display("pixel_depth_deprojection test passed");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("pixel_depth_deprojection test failed");
		end
		$finish;
	end
endmodule
